// ===== rtl/core/isef_pkg.sv =====
// ----------------------------------------------------------------------------
// isef_pkg
// Shared types and constants of the ISEF line smoother: controller states,
// multiplier operand selects, command/status bundles and fixed-point widths.
// ----------------------------------------------------------------------------
package isef_pkg;

  // Field and arithmetic widths
  localparam int SAMPLE_W   = 16;               // Q8.8 sample and result
  localparam int GAIN_W     = 16;               // Q0.16 coefficients
  localparam int STORE_W    = 24;               // Q8.16 recursion values
  localparam int PROD_W     = GAIN_W + STORE_W; // shared multiplier product
  localparam int GAIN_LSB   = 8;                // Q8.24 -> Q8.16
  localparam int DECAY_LSB  = 16;               // Q8.32 -> Q8.16
  localparam int OUT_LSB    = 8;                // Q8.16 -> Q8.8

  // Register file
  localparam int REG_ADDR_W = 4;
  localparam int PDATA_W    = 32;
  localparam logic [1:0] REG_DECAY      = 2'd0;
  localparam logic [1:0] REG_CAUSAL     = 2'd1;
  localparam logic [1:0] REG_ANTICAUSAL = 2'd2;

  localparam logic [GAIN_W-1:0] DECAY_RST      = 16'd59638;
  localparam logic [GAIN_W-1:0] CAUSAL_RST     = 16'd3088;
  localparam logic [GAIN_W-1:0] ANTICAUSAL_RST = 16'd2810;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C_DECAY,
    ST_C_ADD,
    ST_A_READ,
    ST_A_GAIN,
    ST_A_DECAY,
    ST_A_ADD,
    ST_E_READ,
    ST_E_LOAD
  } isef_state_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_CGAIN,
    MUL_AGAIN,
    MUL_DECAY
  } isef_mul_t;

  typedef struct packed {
    logic      load;     // take request, start causal gain product
    isef_mul_t mul;      // shared multiplier operand select
    logic      acc_load; // capture gain term
    logic      c_add;    // finish causal value, store it
    logic      s_read;   // read sample store at index
    logic      a_add;    // finish anticausal value, store it
    logic      e_read;   // read causal and anticausal stores
    logic      e_load;   // load output register
  } isef_cmd_t;

  typedef struct packed {
    logic seg_end;   // current request closes the line
    logic idx_zero;  // index at first sample
    logic idx_last;  // index at last sample of the line
    logic out_free;  // output register can take a result
  } isef_sts_t;

endpackage

// ===== rtl/core/isef_ctrl.sv =====
// ----------------------------------------------------------------------------
// isef_ctrl
// Sequencer: load step per request, then backward anticausal pass and
// forward emit pass over the line.
// ----------------------------------------------------------------------------
module isef_ctrl
  import isef_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  isef_sts_t sts,
  output isef_cmd_t cmd
);

  isef_state_t state_r;
  isef_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul   = MUL_NONE;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cmd.mul   = MUL_CGAIN;
          state_nxt = ST_C_DECAY;
        end
      end
      ST_C_DECAY: begin
        cmd.mul      = MUL_DECAY;
        cmd.acc_load = 1'b1;
        state_nxt    = ST_C_ADD;
      end
      ST_C_ADD: begin
        cmd.c_add = 1'b1;
        state_nxt = sts.seg_end ? ST_A_READ : ST_IDLE;
      end
      ST_A_READ: begin
        cmd.s_read = 1'b1;
        state_nxt  = ST_A_GAIN;
      end
      ST_A_GAIN: begin
        cmd.mul   = MUL_AGAIN;
        state_nxt = ST_A_DECAY;
      end
      ST_A_DECAY: begin
        cmd.mul      = MUL_DECAY;
        cmd.acc_load = 1'b1;
        state_nxt    = ST_A_ADD;
      end
      ST_A_ADD: begin
        cmd.a_add = 1'b1;
        state_nxt = sts.idx_zero ? ST_E_READ : ST_A_READ;
      end
      ST_E_READ: begin
        cmd.e_read = 1'b1;
        state_nxt  = ST_E_LOAD;
      end
      ST_E_LOAD: begin
        if (sts.out_free) begin
          cmd.e_load = 1'b1;
          state_nxt  = sts.idx_last ? ST_IDLE : ST_E_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/isef_dp.sv =====
// ----------------------------------------------------------------------------
// isef_dp
// Datapath: line stores, shared multiplier, recursion adder with
// saturation, line counters and the output register.
// ----------------------------------------------------------------------------
module isef_dp
  import isef_pkg::*;
#(
  parameter int MAX_LINE = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  isef_cmd_t           cmd,
  output isef_sts_t           sts,
  input  logic [GAIN_W-1:0]   decay,
  input  logic [GAIN_W-1:0]   causal_gain,
  input  logic [GAIN_W-1:0]   anticausal_gain,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_line_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_smoothed,
  output logic                out_last_out
);

  localparam int IDX_W = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int CNT_W = $clog2(MAX_LINE + 1);

  logic [SAMPLE_W-1:0] s_mem [MAX_LINE];
  logic [STORE_W-1:0]  c_mem [MAX_LINE];
  logic [STORE_W-1:0]  a_mem [MAX_LINE];

  logic [CNT_W-1:0]    fill_r;
  logic [IDX_W-1:0]    idx_r;
  logic                end_r;
  logic [STORE_W-1:0]  prev_r;
  logic [STORE_W-1:0]  acc_r;
  logic [PROD_W-1:0]   prod_r;
  logic [SAMPLE_W-1:0] s_rd_r;
  logic [STORE_W-1:0]  c_rd_r;
  logic [STORE_W-1:0]  a_rd_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_smoothed_r;
  logic                out_last_r;

  logic [GAIN_W-1:0]   mul_a;
  logic [STORE_W-1:0]  mul_b;
  logic [CNT_W-1:0]    idx_plus;
  logic                idx_last;
  logic                use_decay;
  logic [STORE_W-1:0]  dterm;
  logic [STORE_W:0]    rsum;
  logic [STORE_W-1:0]  rsat;
  logic [STORE_W:0]    esum;
  logic [SAMPLE_W:0]   eshift;
  logic [SAMPLE_W-1:0] esat;

  assign idx_plus = CNT_W'(idx_r) + CNT_W'(1);
  assign idx_last = (idx_plus == fill_r);

  assign sts.seg_end  = end_r || (fill_r == CNT_W'(MAX_LINE - 1));
  assign sts.idx_zero = (idx_r == '0);
  assign sts.idx_last = idx_last;
  assign sts.out_free = !out_valid_r || out_ready;

  // Shared multiplier operand select
  always_comb begin
    case (cmd.mul)
      MUL_CGAIN: begin
        mul_a = causal_gain;
        mul_b = STORE_W'(in_sample);
      end
      MUL_AGAIN: begin
        mul_a = anticausal_gain;
        mul_b = STORE_W'(s_rd_r);
      end
      MUL_DECAY: begin
        mul_a = decay;
        mul_b = prev_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Recursion: gain term plus decayed neighbor, saturate to 24 bits
  assign use_decay = cmd.c_add ? (idx_r != '0) : !idx_last;
  assign dterm     = prod_r[DECAY_LSB +: STORE_W];
  assign rsum      = {1'b0, acc_r} + {1'b0, (use_decay ? dterm : '0)};
  assign rsat      = rsum[STORE_W] ? '1 : rsum[STORE_W-1:0];

  // Emit: A[i] + B[i+1], drop to Q8.8, saturate to 16 bits
  assign esum   = {1'b0, c_rd_r} + {1'b0, (idx_last ? '0 : a_rd_r)};
  assign eshift = esum[OUT_LSB +: SAMPLE_W + 1];
  assign esat   = eshift[SAMPLE_W] ? '1 : eshift[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_mem[fill_r[IDX_W-1:0]] <= in_sample;
    end
    if (cmd.c_add) begin
      c_mem[idx_r] <= rsat;
    end
    if (cmd.a_add) begin
      a_mem[idx_r] <= rsat;
    end
    if (cmd.s_read) begin
      s_rd_r <= s_mem[idx_r];
    end
    if (cmd.e_read) begin
      c_rd_r <= c_mem[idx_r];
      a_rd_r <= a_mem[idx_plus[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul != MUL_NONE) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.acc_load) begin
      acc_r <= prod_r[GAIN_LSB +: STORE_W];
    end
    if (cmd.c_add || cmd.a_add) begin
      prev_r <= rsat;
    end
    if (cmd.load) begin
      end_r <= in_line_end;
      idx_r <= fill_r[IDX_W-1:0];
    end else if (cmd.a_add && (idx_r != '0)) begin
      idx_r <= idx_r - IDX_W'(1);
    end else if (cmd.e_load && !idx_last) begin
      idx_r <= idx_plus[IDX_W-1:0];
    end
    if (cmd.e_load) begin
      out_smoothed_r <= esat;
      out_last_r     <= idx_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.c_add) begin
        fill_r <= fill_r + CNT_W'(1);
      end else if (cmd.e_load && idx_last) begin
        fill_r <= '0;
      end
      if (cmd.e_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_smoothed = out_smoothed_r;
  assign out_last_out = out_last_r;

endmodule

// ===== rtl/core/isef_recursive_line_smoother.sv =====
// ----------------------------------------------------------------------------
// isef_recursive_line_smoother
// One-dimensional ISEF (Shen-Castan) recursive smoothing of one image line.
// ----------------------------------------------------------------------------
// Samples (unsigned Q8.8) of one line arrive as requests on the in_ channel,
// the last one marked by in_line_end; a line that reaches MAX_LINE samples
// closes there and the next request opens a new line. A request is taken
// only while idle; the causal sum A[i] = g1*x[i] + b*A[i-1] is formed on
// load with a single shared 16x24 multiplier that computes the gain and
// decay products one after the other. When a line of n samples closes, the
// block runs a backward anticausal pass, B[i] = g2*x[i] + b*B[i+1], one
// sample at a time (store read, two products, add and write), then emits
// the n results y[i] = A[i] + B[i+1] (y[n-1] = A[n-1]) in order, each read
// from the stores and then loaded into the output register once it is free;
// out_last_out marks the final one. No sample of a new line is taken
// during the two passes. Stored values are Q8.16, saturated at 24 bits;
// results are truncated to Q8.8 and saturated at 65535. The coefficients
// decay (b), causal_gain (g1) and anticausal_gain (g2), all Q0.16, sit at
// byte addresses 0, 4 and 8 of the APB port; write them only while the
// block is idle. Run the block once along rows and once along columns,
// feeding the second pass with the output of the first, for the 2D filter.
// ----------------------------------------------------------------------------
module isef_recursive_line_smoother
  import isef_pkg::*;
#(
  parameter int MAX_LINE = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // sample requests
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic                  in_line_end,
  // smoothed results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_smoothed,
  output logic                  out_last_out,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  logic [GAIN_W-1:0] decay_r;
  logic [GAIN_W-1:0] causal_gain_r;
  logic [GAIN_W-1:0] anticausal_gain_r;
  logic [1:0]        reg_idx;
  logic              reg_wr;

  isef_cmd_t cmd;
  isef_sts_t sts;

  // Register file: word index from the byte address, unknown indexes drop
  assign reg_idx = paddr[REG_ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r           <= DECAY_RST;
      causal_gain_r     <= CAUSAL_RST;
      anticausal_gain_r <= ANTICAUSAL_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_DECAY:      decay_r           <= pwdata[GAIN_W-1:0];
        REG_CAUSAL:     causal_gain_r     <= pwdata[GAIN_W-1:0];
        REG_ANTICAUSAL: anticausal_gain_r <= pwdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DECAY:      prdata = PDATA_W'(decay_r);
      REG_CAUSAL:     prdata = PDATA_W'(causal_gain_r);
      REG_ANTICAUSAL: prdata = PDATA_W'(anticausal_gain_r);
      default:        prdata = '0;
    endcase
  end

  // Sequencer: one state per step of load, anticausal and emit passes
  isef_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Stores, shared multiplier, adder and output register
  isef_dp #(
    .MAX_LINE (MAX_LINE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .decay           (decay_r),
    .causal_gain     (causal_gain_r),
    .anticausal_gain (anticausal_gain_r),
    .in_sample       (in_sample),
    .in_line_end     (in_line_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_smoothed    (out_smoothed),
    .out_last_out    (out_last_out)
  );

endmodule

// ===== rtl/core/isef_checker.sv =====
// ----------------------------------------------------------------------------
// isef_checker
// Port-level checks of the ISEF line smoother, bound to the top level.
// ----------------------------------------------------------------------------
module isef_checker
  import isef_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] out_smoothed,
  input logic                out_last_out
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_smoothed) && $stable(out_last_out))
    else $error("result changed while stalled");

  // Each request occupies the load sequence for its full length
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("request taken during load sequence");

  // Reset drops any pending result
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind isef_recursive_line_smoother isef_checker u_isef_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_smoothed (out_smoothed),
  .out_last_out (out_last_out)
);

// ===== tb/tb_isef_recursive_line_smoother.sv =====
// ----------------------------------------------------------------------------
// tb_isef_recursive_line_smoother
// Self-checking bench for the ISEF line smoother. Sample requests go in over
// the in_ channel, and a line-level predictor rebuilds the causal and
// anticausal recursions in fixed point to queue the expected results. Every
// result leaving the out_ channel is compared field by field. Coefficients
// are changed over the APB port between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_isef_recursive_line_smoother;
  import isef_pkg::*;

  localparam int MAX_LINE = 64;
  localparam int LIMIT_TIME = 5_000_000;
  localparam int SETTLE_CYCLES = 20;

  // Register byte addresses; index 3 has no register behind it
  localparam logic [REG_ADDR_W-1:0] ADDR_DECAY      = {REG_DECAY, 2'b00};
  localparam logic [REG_ADDR_W-1:0] ADDR_CAUSAL     = {REG_CAUSAL, 2'b00};
  localparam logic [REG_ADDR_W-1:0] ADDR_ANTICAUSAL = {REG_ANTICAUSAL, 2'b00};
  localparam logic [REG_ADDR_W-1:0] ADDR_UNUSED     = 4'd12;

  typedef struct {
    logic [SAMPLE_W-1:0] smoothed;
    logic                last_out;
  } smooth_result_t;

  logic                  clk;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_sample    = '0;
  logic                  in_line_end  = 1'b0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [SAMPLE_W-1:0]   out_smoothed;
  logic                  out_last_out;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [REG_ADDR_W-1:0] paddr        = '0;
  logic [PDATA_W-1:0]    pwdata       = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  // Predictor copy of the coefficients and line stores
  logic [GAIN_W-1:0]  decay_coef      = DECAY_RST;
  logic [GAIN_W-1:0]  cgain_coef      = CAUSAL_RST;
  logic [GAIN_W-1:0]  again_coef      = ANTICAUSAL_RST;
  logic [SAMPLE_W-1:0] line_samples [MAX_LINE];
  logic [STORE_W-1:0]  line_causal  [MAX_LINE];
  logic [STORE_W-1:0]  line_anti    [MAX_LINE];
  int                  line_fill = 0;

  smooth_result_t smoothed_q[$];
  int mismatches = 0;

  // Stimulus knobs: idle percentages and a pending receiver hold-off
  int in_idle_pct  = 31;
  int out_idle_pct = 31;
  int hold_req     = 0;
  int hold_left    = 0;

  isef_recursive_line_smoother #(.MAX_LINE(MAX_LINE)) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .in_line_end  (in_line_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_smoothed (out_smoothed),
    .out_last_out (out_last_out),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // Q0.16 gain times Q8.8 sample, truncated to Q8.16
  function automatic logic [63:0] gain_prod(logic [GAIN_W-1:0] g, logic [SAMPLE_W-1:0] x);
    return ({48'd0, g} * {48'd0, x}) >> GAIN_LSB;
  endfunction

  // Q0.16 decay times Q8.16 store value, truncated to Q8.16
  function automatic logic [63:0] decay_prod(logic [STORE_W-1:0] v);
    return ({48'd0, decay_coef} * {40'd0, v}) >> DECAY_LSB;
  endfunction

  function automatic logic [STORE_W-1:0] clamp_store(logic [63:0] v);
    return (v > 64'hFF_FFFF) ? {STORE_W{1'b1}} : v[STORE_W-1:0];
  endfunction

  // Fold one accepted request into the line; when the line closes, run the
  // backward pass and queue every result of the line in order.
  task automatic predict_sample(input logic [SAMPLE_W-1:0] x, input logic line_end);
    int n;
    logic [63:0] acc;
    smooth_result_t r;
    n = line_fill;
    if (n >= MAX_LINE) n = 0;
    acc = gain_prod(cgain_coef, x);
    if (n > 0) acc += decay_prod(line_causal[n-1]);
    line_causal[n]  = clamp_store(acc);
    line_samples[n] = x;
    n++;
    if (!line_end && n < MAX_LINE) begin
      line_fill = n;
      return;
    end
    line_anti[n-1] = clamp_store(gain_prod(again_coef, line_samples[n-1]));
    for (int i = n - 2; i >= 0; i--) begin
      line_anti[i] = clamp_store(gain_prod(again_coef, line_samples[i]) +
                                 decay_prod(line_anti[i+1]));
    end
    for (int i = 0; i < n; i++) begin
      acc = {40'd0, line_causal[i]};
      if (i + 1 < n) acc += {40'd0, line_anti[i+1]};
      acc = acc >> OUT_LSB;
      r.smoothed = (acc > 64'hFFFF) ? 16'hFFFF : acc[SAMPLE_W-1:0];
      r.last_out = (i == n - 1);
      smoothed_q.push_back(r);
    end
    line_fill = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls plus an on-demand long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    smooth_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (smoothed_q.size() == 0) begin
        $error("unexpected result: smoothed=%0d last_out=%0b", out_smoothed, out_last_out);
        mismatches++;
      end else begin
        want = smoothed_q.pop_front();
        if (out_smoothed !== want.smoothed) begin
          $error("smoothed: expected %0d, got %0d", want.smoothed, out_smoothed);
          mismatches++;
        end
        if (out_last_out !== want.last_out) begin
          $error("last_out: expected %0b, got %0b", want.last_out, out_last_out);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers; every task starts and ends just after a falling edge
  // ---------------------------------------------------------------------------

  // Send one sample request; leave valid high so a following request can go
  // back to back without a bubble.
  task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic line_end);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid    <= 1'b1;
    in_sample   <= x;
    in_line_end <= line_end;
    do @(posedge clk); while (!in_ready);
    predict_sample(x, line_end);
    @(negedge clk);
  endtask

  // Drop valid and wait for every queued result, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [REG_ADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr[3:2])
      REG_DECAY:      decay_coef = data[GAIN_W-1:0];
      REG_CAUSAL:     cgain_coef = data[GAIN_W-1:0];
      REG_ANTICAUSAL: again_coef = data[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_check(input logic [REG_ADDR_W-1:0] addr, input logic [GAIN_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {{(PDATA_W-GAIN_W){1'b0}}, want}) begin
      $error("prdata at address %0d: expected %0d, got %0d", addr, want, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write all three coefficients with junk in the upper data bits, then
  // read them back.
  task automatic set_coefs(input logic [GAIN_W-1:0] b, input logic [GAIN_W-1:0] g1,
                           input logic [GAIN_W-1:0] g2);
    apb_write(ADDR_DECAY,      {16'($urandom), b});
    apb_write(ADDR_CAUSAL,     {16'($urandom), g1});
    apb_write(ADDR_ANTICAUSAL, {16'($urandom), g2});
    apb_check(ADDR_DECAY,      decay_coef);
    apb_check(ADDR_CAUSAL,     cgain_coef);
    apb_check(ADDR_ANTICAUSAL, again_coef);
  endtask

  // Mostly full-range samples, with the range ends and small values mixed in
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  // Send a line of random samples, end mark on the final one. Lines longer
  // than the store get split by the block itself.
  task automatic send_line(input int len);
    for (int k = 0; k < len; k++) send_sample(pick_sample(), k == len - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset coefficients: range ends, a short line and single-sample lines
  task automatic test_reset_defaults();
    apb_check(ADDR_DECAY,      DECAY_RST);
    apb_check(ADDR_CAUSAL,     CAUSAL_RST);
    apb_check(ADDR_ANTICAUSAL, ANTICAUSAL_RST);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0001, 1'b1);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b1);
    wait_idle();
  endtask

  // Register writes, excess data bits, and a write to an unmapped index
  task automatic test_registers();
    set_coefs(16'd52429, 16'd5958, 16'd4766);
    apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    apb_check(ADDR_DECAY,      decay_coef);
    apb_check(ADDR_CAUSAL,     cgain_coef);
    apb_check(ADDR_ANTICAUSAL, again_coef);
    send_sample(16'h1234, 1'b0);
    send_sample(16'hABCD, 1'b0);
    send_sample(16'h00FF, 1'b1);
    wait_idle();
  endtask

  // Coefficient extremes: everything at full scale forces store and output
  // saturation; zero decay leaves only the gain terms, and zero gains give zero.
  task automatic test_saturation();
    set_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (3) send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    wait_idle();
    set_coefs(16'h0000, 16'hFFFF, 16'h8000);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    wait_idle();
    set_coefs(16'hFFFF, 16'h0000, 16'h0000);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    wait_idle();
  endtask

  // Full store: a line closes at MAX_LINE without an end mark, the next
  // request opens a new one; then a line whose end mark lands on the last slot.
  // Run the whole stretch with no idling on either side.
  task automatic test_full_line();
    set_coefs(DECAY_RST, CAUSAL_RST, ANTICAUSAL_RST);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    for (int k = 0; k < MAX_LINE; k++) send_sample(pick_sample(), 1'b0);
    send_sample(pick_sample(), 1'b1);
    send_line(MAX_LINE);
    wait_idle();
    in_idle_pct  = 31;
    out_idle_pct = 31;
  endtask

  // Long receiver hold-off while requests keep coming, so the block fills,
  // stalls its output and stops taking samples.
  task automatic test_backpressure();
    in_idle_pct = 0;
    hold_req    = 400;
    repeat (4) send_line($urandom_range(4, 12));
    wait_idle();
    in_idle_pct = 31;
  endtask

  // Random lines across several coefficient settings; one phase runs with
  // no idling on either side.
  task automatic test_random_lines();
    int sent;
    int len;
    logic [GAIN_W-1:0] b;
    logic [GAIN_W-1:0] g1;
    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0, 3: begin
          // realistic gains derived from a random decay
          b  = 16'($urandom_range(40000, 65000));
          g1 = 16'(((65536 - 32'(b)) * 65536) / (65536 + 32'(b)));
          set_coefs(b, g1, 16'((32'(b) * 32'(g1)) >> 16));
        end
        1:       set_coefs(16'($urandom), 16'($urandom), 16'($urandom));
        2:       set_coefs(16'hFFFF, 16'($urandom), 16'($urandom));
        4:       set_coefs(16'h0000, 16'($urandom), 16'($urandom));
        default: set_coefs(DECAY_RST, CAUSAL_RST, ANTICAUSAL_RST);
      endcase
      if (phase == 3) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      while (sent < 5 * (phase + 1)) begin
        len = ($urandom_range(99) < 8) ? $urandom_range(60, 80) : $urandom_range(1, 12);
        send_line(len);
        sent += len;
      end
      wait_idle();
      in_idle_pct  = 31;
      out_idle_pct = 31;
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_registers();
    test_saturation();
    test_full_line();
    test_backpressure();
    test_random_lines();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #LIMIT_TIME;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/isef_pkg.sv
rtl/core/isef_ctrl.sv
rtl/core/isef_dp.sv
rtl/core/isef_recursive_line_smoother.sv
rtl/core/isef_checker.sv
tb/tb_isef_recursive_line_smoother.sv
